// ===== sv/hgns_pkg.sv =====
package hgns_pkg;

    typedef enum logic [1:0] {
        DIR_DOWN,
        DIR_UP,
        DIR_RIGHT,
        DIR_LEFT
    } dir_t;

    typedef enum logic [1:0] {
        REG_DIRECTION,
        REG_ROW_COUNT,
        REG_COL_COUNT,
        REG_ODD_PARITY
    } reg_idx_t;

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } state_t;

    localparam int ADDR_W = 4;
    localparam int COL_W  = 16;
    localparam int RCNT_W = 6;
    localparam int SEEN_W = 7;
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

endpackage

// ===== sv/hex_grid_neighbour_shift.sv =====
// Streams a column-major hexagonal grid and returns it shifted one cell down, up, right or
// left, NA where a cell has no source. Down and right give one result per element, one
// element per cycle while the output is not stalled. Up lags one element and adds one
// extra result after the last element. Left lags one column and, after the last element,
// drains the last column from the line store at one result per cycle while the output is
// not stalled and input is held off: the effective row count of results once a full column
// has been seen, else one per element of the vector. The line store has one read and one
// write port and a registered read; its next address is prefetched from next-state values
// and a same-entry write is forwarded, so the memory port sustains one element per cycle.
// Results leave through an output register. Any register write restarts the stream.
module hex_grid_neighbour_shift
    import hgns_pkg::*;
#(
    parameter int ROWS       = 63,
    parameter int ELEM_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // element stream
    input  logic              elem_valid,
    output logic              elem_ready,
    input  logic [31:0]       elem_value,
    input  logic              elem_is_na,
    input  logic              elem_last,
    // result stream
    output logic              res_valid,
    input  logic              res_ready,
    output logic [31:0]       out_value,
    output logic              out_is_na,
    output logic              out_last
);

    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int STORE_W = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;
    localparam int DATA_W  = STORE_W + 1;

    // configuration
    dir_t              direction_reg;
    logic [RCNT_W-1:0] row_count_reg;
    logic [COL_W-1:0]  col_count_reg;
    logic              odd_parity_reg;

    // stream position
    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_pos_reg, row_pos_next;
    logic [COL_W-1:0]  col_pos_reg, col_pos_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [ROW_W-1:0]  store_head_reg, store_head_next;
    logic [ROW_W-1:0]  flush_k_reg, flush_k_next;
    logic [ROW_W-1:0]  flush_end_reg, flush_end_next;

    // output register
    logic              out_valid_reg;
    logic [31:0]       out_value_reg;
    logic              out_is_na_reg;
    logic              out_last_reg;

    // line store
    logic [DATA_W-1:0] mem [ROWS];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    logic [DATA_W-1:0] mem_q;
    logic [ROW_W-1:0]  rd_addr;
    logic              wr_en;
    logic [DATA_W-1:0] in_data;

    logic              cfg_wr;
    logic              accept;
    logic              slot_free;
    logic [SEEN_W-1:0] rows_eff;
    logic [ROW_W-1:0]  rows_m1;
    logic [COL_W-1:0]  cols_m1;
    logic              emit;
    logic [STORE_W-1:0] res_val;
    logic              res_na;
    logic              res_last;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign slot_free = !out_valid_reg || res_ready;
    assign elem_ready = (state_reg == ST_RUN) && slot_free;
    assign accept    = elem_valid && elem_ready;
    assign in_data   = {elem_is_na, elem_value[STORE_W-1:0]};
    assign mem_q     = fwd_reg ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = SEEN_W'(1);
        else if (row_count_reg > RCNT_W'(ROWS))
            rows_eff = SEEN_W'(ROWS);
        else
            rows_eff = SEEN_W'(row_count_reg);
    end

    assign rows_m1 = ROW_W'(rows_eff - SEEN_W'(1));
    assign cols_m1 = (col_count_reg == '0) ? '0 : col_count_reg - COL_W'(1);

    // register port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= DIR_DOWN;
            row_count_reg  <= RCNT_W'(1);
            col_count_reg  <= COL_W'(1);
            odd_parity_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_DIRECTION:  direction_reg  <= dir_t'(pwdata[1:0]);
                REG_ROW_COUNT:  row_count_reg  <= pwdata[RCNT_W-1:0];
                REG_COL_COUNT:  col_count_reg  <= pwdata[COL_W-1:0];
                REG_ODD_PARITY: odd_parity_reg <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_DIRECTION:  prdata = 32'(direction_reg);
            REG_ROW_COUNT:  prdata = 32'(row_count_reg);
            REG_COL_COUNT:  prdata = 32'(col_count_reg);
            REG_ODD_PARITY: prdata = 32'(odd_parity_reg);
        endcase
    end

    // sequencing, result selection and line store addressing
    always_comb
    begin
        state_next      = state_reg;
        row_pos_next    = row_pos_reg;
        col_pos_next    = col_pos_reg;
        seen_next       = seen_reg;
        store_head_next = store_head_reg;
        flush_k_next    = flush_k_reg;
        flush_end_next  = flush_end_reg;
        emit            = 1'b0;
        res_val         = '0;
        res_na          = 1'b1;
        res_last        = 1'b0;
        wr_en           = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    wr_en           = 1'b1;
                    store_head_next = row_pos_reg;
                    unique case (direction_reg)
                        DIR_DOWN:
                        begin
                            emit     = 1'b1;
                            res_last = elem_last;
                            if (row_pos_reg != '0)
                                {res_na, res_val} = mem_q;
                        end
                        DIR_UP:
                        begin
                            if (seen_reg != '0)
                            begin
                                emit = 1'b1;
                                if (row_pos_reg != '0)
                                    {res_na, res_val} = in_data;
                                if (elem_last)
                                    state_next = ST_FLUSH;
                            end
                            else if (elem_last)
                            begin
                                // single element: one NA that closes the vector
                                emit     = 1'b1;
                                res_last = 1'b1;
                            end
                        end
                        DIR_RIGHT:
                        begin
                            emit     = 1'b1;
                            res_last = elem_last;
                            if (row_pos_reg[0] == odd_parity_reg)
                                {res_na, res_val} = in_data;
                            else if (col_pos_reg != '0)
                                {res_na, res_val} = mem_q;
                        end
                        DIR_LEFT:
                        begin
                            if (seen_reg >= rows_eff)
                            begin
                                emit = 1'b1;
                                if (row_pos_reg[0] == odd_parity_reg)
                                    {res_na, res_val} = mem_q;
                                else if (col_pos_reg != '0)
                                    {res_na, res_val} = in_data;
                            end
                            if (elem_last)
                            begin
                                state_next     = ST_FLUSH;
                                flush_end_next = row_pos_reg;
                                // drain the previous column's tail first, if there is one
                                if (seen_reg >= rows_eff && row_pos_reg != rows_m1)
                                    flush_k_next = row_pos_reg + ROW_W'(1);
                                else
                                    flush_k_next = '0;
                            end
                        end
                    endcase

                    if (elem_last)
                    begin
                        row_pos_next = '0;
                        col_pos_next = '0;
                        seen_next    = '0;
                    end
                    else
                    begin
                        if (row_pos_reg == rows_m1)
                        begin
                            row_pos_next = '0;
                            col_pos_next = (col_pos_reg == cols_m1) ? '0
                                                                    : col_pos_reg + COL_W'(1);
                        end
                        else
                        begin
                            row_pos_next = row_pos_reg + ROW_W'(1);
                        end
                        if (seen_reg != SEEN_MAX)
                            seen_next = seen_reg + SEEN_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (direction_reg == DIR_LEFT)
                    begin
                        if (flush_k_reg[0] == odd_parity_reg)
                            {res_na, res_val} = mem_q;
                        res_last     = (flush_k_reg == flush_end_reg);
                        flush_k_next = (flush_k_reg == rows_m1) ? '0
                                                                : flush_k_reg + ROW_W'(1);
                        if (flush_k_reg == flush_end_reg)
                            state_next = ST_RUN;
                    end
                    else
                    begin
                        res_last   = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
        endcase

        if (cfg_wr)
        begin
            state_next      = ST_RUN;
            row_pos_next    = '0;
            col_pos_next    = '0;
            seen_next       = '0;
            store_head_next = '0;
        end

        // prefetch the entry the next cycle will need
        priority if (cfg_wr)
            rd_addr = '0;
        else if (state_next == ST_FLUSH)
            rd_addr = flush_k_next;
        else if (direction_reg == DIR_DOWN)
            rd_addr = store_head_next;
        else
            rd_addr = row_pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            seen_reg       <= '0;
            store_head_reg <= '0;
            flush_k_reg    <= '0;
            flush_end_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_pos_reg    <= row_pos_next;
            col_pos_reg    <= col_pos_next;
            seen_reg       <= seen_next;
            store_head_reg <= store_head_next;
            flush_k_reg    <= flush_k_next;
            flush_end_reg  <= flush_end_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= res_na ? '0 : 32'(res_val);
            out_is_na_reg <= res_na;
            out_last_reg  <= res_last;
        end
    end

    // line store: write-first forwarding when the prefetch hits the entry being written
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[row_pos_reg] <= in_data;
        rd_data_reg  <= mem[rd_addr];
        fwd_reg      <= wr_en && (row_pos_reg == rd_addr);
        fwd_data_reg <= in_data;
    end

    assign res_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_is_na = out_is_na_reg;
    assign out_last  = out_last_reg;

    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && elem_last && !cfg_wr
            && (direction_reg == DIR_DOWN || direction_reg == DIR_RIGHT)
        |=> res_valid && out_last)
        else $error("down/right result for the last element not flagged last");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_pos_reg <= rows_m1)
        else $error("row position beyond row count");

    a_flush_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FLUSH && direction_reg == DIR_LEFT
        |-> flush_k_reg <= rows_m1 && flush_end_reg <= rows_m1)
        else $error("left drain index beyond row count");

    a_flush_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        accept && elem_last && !cfg_wr && direction_reg == DIR_LEFT
        |=> !elem_ready)
        else $error("input taken while left drain pending");

endmodule
